@@ sv/rc_csv_frame_parser_macros.svh @@
// ----------------------------------------------------------------------------
// rc_csv_frame_parser assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef RC_CSV_FRAME_PARSER_MACROS_SVH
`define RC_CSV_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define RCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcp port check failed");

// next-cycle implication
`define RCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcp port check failed");

`endif

@@ sv/rcp_pkg.sv @@
// ----------------------------------------------------------------------------
// rcp_pkg
// types, character codes and constants of the text rc frame parser
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int CH_W       = 16;
  localparam int VAL_W      = 17;
  localparam int PFX_W      = 4;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int PREFIX_LEN = 9;

  localparam logic [VAL_W-1:0] VALUE_SAT = 17'h10000;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam logic [CH_W-1:0] TIMEOUT_RST   = 16'd500;
  localparam logic [CH_W-1:0] VALID_MIN_RST = 16'd800;
  localparam logic [CH_W-1:0] VALID_MAX_RST = 16'd2200;
  localparam logic [CH_W-1:0] FILL_RST      = 16'd1500;

  typedef enum logic [4:0] {
    PH_SEEK   = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_SEP    = 5'b01000,
    PH_STOP   = 5'b10000
  } phase_t;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_VALID_MIN = 2'd1,
    REG_VALID_MAX = 2'd2,
    REG_FILL      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] timeout_ticks;
    logic [CH_W-1:0] valid_min;
    logic [CH_W-1:0] valid_max;
    logic [CH_W-1:0] fill_value;
  } cfg_regs_t;

  function automatic logic [7:0] loss_prefix_char(input logic [PFX_W-1:0] i);
    logic [7:0] ch;
    unique case (i)
      4'd0:    ch = 8'h4E;
      4'd1:    ch = 8'h4F;
      4'd2:    ch = 8'h5F;
      4'd3:    ch = 8'h53;
      4'd4:    ch = 8'h49;
      4'd5:    ch = 8'h47;
      4'd6:    ch = 8'h4E;
      4'd7:    ch = 8'h41;
      4'd8:    ch = 8'h4C;
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [CH_W-1:0] hover_value(input int k);
    logic [CH_W-1:0] v;
    if (k == 2) begin
      v = 16'd1300;
    end else if (k == 4) begin
      v = 16'd2000;
    end else begin
      v = 16'd1500;
    end
    return v;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SP) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

@@ sv/rcp_front.sv @@
// ----------------------------------------------------------------------------
// rcp_front
// byte and tick intake, line parser, held frame and frame request issue
// ----------------------------------------------------------------------------
module rcp_front
  import rcp_pkg::*;
#(
  parameter int NUM_CHANNELS  = 14,
  parameter int LINE_CAPACITY = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cfg_regs_t                           cfg,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_operation,
  input  logic [7:0]                          in_byte_req,
  input  logic                                q_full,
  output logic                                q_push,
  output logic                                q_failsafe,
  output logic [NUM_CHANNELS-1:0][CH_W-1:0]   q_frame
);

  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int LEN_W = $clog2(LINE_CAPACITY);

  phase_t                           phase_r, phase_nxt;
  logic [VAL_W-1:0]                 val_r, val_nxt;
  logic                             neg_r, neg_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [LEN_W-1:0]                 len_r, len_nxt;
  logic [PFX_W-1:0]                 pfx_r, pfx_nxt;
  logic [CH_W-1:0]                  idle_r, idle_nxt;
  logic [NUM_CHANNELS-1:0][CH_W-1:0] held_r, held_nxt;
  logic [NUM_CHANNELS-1:0][CH_W-1:0] line_r, line_e;

  logic                             acc;
  logic [VAL_W-1:0]                 dval;
  logic [VAL_W+3:0]                 mul10;
  phase_t                           ph_s;
  logic [VAL_W-1:0]                 v_s;
  logic                             ng_s;
  logic                             done_s;
  logic                             step_commit;
  logic [CNT_W-1:0]                 cnt_c;
  logic                             pfx_hit;
  logic [PFX_W-1:0]                 pfx_after;
  logic [LEN_W-1:0]                 len_new;
  logic                             cap_end;
  logic                             we;
  logic [VAL_W-1:0]                 cv;
  logic                             cn;
  logic [CH_W-1:0]                  okv;
  logic [CNT_W-1:0]                 count_e;
  logic [PFX_W-1:0]                 pfx_e;
  logic                             line_end;
  logic [CH_W-1:0]                  idle_inc;

  assign acc     = in_push && !q_full;
  assign in_full = q_full;
  assign dval    = VAL_W'(in_byte_req[3:0]);
  assign mul10   = {val_r, 3'b000} + {2'b00, val_r, 1'b0} + (VAL_W+4)'(in_byte_req[3:0]);

  // one byte through the parser
  always_comb begin
    ph_s        = phase_r;
    v_s         = val_r;
    ng_s        = neg_r;
    done_s      = 1'b0;
    step_commit = 1'b0;
    if (ph_s == PH_DIGITS) begin
      if (is_digit(in_byte_req)) begin
        v_s    = (mul10 > (VAL_W+4)'(VALUE_SAT)) ? VALUE_SAT : mul10[VAL_W-1:0];
        done_s = 1'b1;
      end else begin
        step_commit = 1'b1;
        ph_s        = PH_SEP;
      end
    end
    cnt_c = cnt_r + CNT_W'(step_commit && (cnt_r < CNT_W'(NUM_CHANNELS)));
    if (!done_s && ph_s == PH_SEP) begin
      if (cnt_c >= CNT_W'(NUM_CHANNELS)) begin
        ph_s   = PH_STOP;
        done_s = 1'b1;
      end else if (in_byte_req == CHAR_COMMA || in_byte_req == CHAR_SP) begin
        done_s = 1'b1;
      end else begin
        ph_s = PH_SEEK;
      end
    end
    if (!done_s && ph_s == PH_SEEK) begin
      done_s = 1'b1;
      if (in_byte_req == CHAR_NUL) begin
        ph_s = PH_STOP;
      end else if (is_blank(in_byte_req)) begin
        ph_s = PH_SEEK;
      end else if (in_byte_req == CHAR_PLUS || in_byte_req == CHAR_MINUS) begin
        ng_s = (in_byte_req == CHAR_MINUS);
        v_s  = '0;
        ph_s = PH_SIGN;
      end else if (is_digit(in_byte_req)) begin
        ng_s = 1'b0;
        v_s  = dval;
        ph_s = PH_DIGITS;
      end else begin
        ph_s = PH_STOP;
      end
    end else if (!done_s && ph_s == PH_SIGN) begin
      done_s = 1'b1;
      if (is_digit(in_byte_req)) begin
        v_s  = dval;
        ph_s = PH_DIGITS;
      end else begin
        ph_s = PH_STOP;
      end
    end
  end

  assign pfx_hit   = (len_r < LEN_W'(PREFIX_LEN)) && (LEN_W'(pfx_r) == len_r) &&
                     (in_byte_req == loss_prefix_char(len_r[PFX_W-1:0]));
  assign pfx_after = pfx_r + PFX_W'(pfx_hit);
  assign len_new   = len_r + LEN_W'(1);
  assign cap_end   = {1'b0, len_new} >= (LEN_W+1)'(LINE_CAPACITY - 1);

  // channel commit for this request
  always_comb begin
    we = 1'b0;
    cv = val_r;
    cn = neg_r;
    if (acc && in_operation == OP_BYTE && in_byte_req != CHAR_CR) begin
      if (in_byte_req == CHAR_LF) begin
        we = (phase_r == PH_DIGITS);
      end else if (step_commit) begin
        we = 1'b1;
      end else if (cap_end && ph_s == PH_DIGITS) begin
        we = 1'b1;
        cv = v_s;
        cn = ng_s;
      end
    end
    we  = we && (cnt_r < CNT_W'(NUM_CHANNELS));
    okv = (!(cn && cv != '0) && cv >= {1'b0, cfg.valid_min} &&
           cv <= {1'b0, cfg.valid_max}) ? cv[CH_W-1:0] : cfg.fill_value;
    count_e = cnt_r + CNT_W'(we);
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      line_e[k] = (we && cnt_r == CNT_W'(k)) ? okv : line_r[k];
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    val_nxt    = val_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    pfx_nxt    = pfx_r;
    idle_nxt   = idle_r;
    held_nxt   = held_r;
    q_push     = 1'b0;
    q_failsafe = 1'b0;
    q_frame    = held_r;
    line_end   = 1'b0;
    pfx_e      = pfx_r;
    idle_inc   = (idle_r == '1) ? idle_r : idle_r + CH_W'(1);
    if (acc && in_operation == OP_TICK) begin
      if (idle_inc >= cfg.timeout_ticks) begin
        idle_nxt   = '0;
        phase_nxt  = PH_SEEK;
        val_nxt    = '0;
        neg_nxt    = 1'b0;
        cnt_nxt    = '0;
        len_nxt    = '0;
        pfx_nxt    = '0;
        q_push     = 1'b1;
        q_failsafe = 1'b1;
      end else begin
        idle_nxt = idle_inc;
      end
    end else if (acc && in_byte_req != CHAR_CR) begin
      idle_nxt = '0;
      if (in_byte_req == CHAR_LF) begin
        line_end = 1'b1;
      end else begin
        phase_nxt = ph_s;
        val_nxt   = v_s;
        neg_nxt   = ng_s;
        cnt_nxt   = count_e;
        len_nxt   = len_new;
        pfx_nxt   = pfx_after;
        pfx_e     = pfx_after;
        line_end  = cap_end;
      end
    end else if (acc) begin
      idle_nxt = '0;
    end
    if (line_end) begin
      if (pfx_e == PFX_W'(PREFIX_LEN)) begin
        q_push     = 1'b1;
        q_failsafe = 1'b1;
      end else if (count_e != '0) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          held_nxt[k] = (CNT_W'(k) < count_e) ? line_e[k] : cfg.fill_value;
        end
        q_push  = 1'b1;
        q_frame = held_nxt;
      end
      phase_nxt = PH_SEEK;
      val_nxt   = '0;
      neg_nxt   = 1'b0;
      cnt_nxt   = '0;
      len_nxt   = '0;
      pfx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      val_r   <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
      len_r   <= '0;
      pfx_r   <= '0;
      idle_r  <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        held_r[k] <= hover_value(k);
      end
    end else begin
      phase_r <= phase_nxt;
      val_r   <= val_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      pfx_r   <= pfx_nxt;
      idle_r  <= idle_nxt;
      held_r  <= held_nxt;
    end
  end

  // line values, written one channel at a time
  always_ff @(posedge clk) begin
    if (we) begin
      line_r <= line_e;
    end
  end

endmodule

@@ sv/rcp_queue.sv @@
// ----------------------------------------------------------------------------
// rcp_queue
// two-entry frame request queue between parser and frame sender
// ----------------------------------------------------------------------------
module rcp_queue
  import rcp_pkg::*;
#(
  parameter int W = 225
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

@@ sv/rcp_back.sv @@
// ----------------------------------------------------------------------------
// rcp_back
// frame sender: serializes one queued frame into channel results
// ----------------------------------------------------------------------------
module rcp_back
  import rcp_pkg::*;
#(
  parameter int NUM_CHANNELS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic                              q_failsafe,
  input  logic [NUM_CHANNELS-1:0][CH_W-1:0] q_frame,
  output logic                              q_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [IDX_W-1:0]                  out_channel_index,
  output logic [CH_W-1:0]                   out_channel_value,
  output logic                              out_failsafe,
  output logic                              out_last
);

  localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [IW-1:0]    idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] oidx_r;
  logic [CH_W-1:0]  oval_r;
  logic             ofs_r;
  logic             olast_r;
  logic             load;
  logic             at_last;

  assign at_last = (idx_r == IW'(NUM_CHANNELS - 1));
  assign load    = !q_empty && (!valid_r || out_pop);
  assign q_pop   = load && at_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = at_last ? '0 : idx_r + IW'(1);
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oidx_r  <= IDX_W'(idx_r);
      oval_r  <= q_frame[idx_r];
      ofs_r   <= q_failsafe;
      olast_r <= at_last;
    end
  end

  assign out_empty         = !valid_r;
  assign out_channel_index = oidx_r;
  assign out_channel_value = oval_r;
  assign out_failsafe      = ofs_r;
  assign out_last          = olast_r;

endmodule

@@ sv/rc_csv_frame_parser.sv @@
// ----------------------------------------------------------------------------
// rc_csv_frame_parser
// text rc frame parser: bytes and ms ticks in, channel results out
// ----------------------------------------------------------------------------
// one byte or tick is taken per cycle while the two-entry frame queue has room
// a line end or timeout queues a frame request, and the frame sender registers its first channel
// a frame then leaves at one channel per cycle while out_pop is held
// the frame sender's channel counter sets the sustained frame rate
// synchronous active-low reset restores config and control registers, hover frame and idle state
module rc_csv_frame_parser
  import rcp_pkg::*;
#(
  parameter int NUM_CHANNELS  = 14,
  parameter int LINE_CAPACITY = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_operation,
  input  logic [7:0]           in_byte_req,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [IDX_W-1:0]     out_channel_index,
  output logic [CH_W-1:0]      out_channel_value,
  output logic                 out_failsafe,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]      cfg_data
);

  localparam int QW = 1 + NUM_CHANNELS * CH_W;

  cfg_regs_t                         cfg_r, cfg_nxt;
  logic                              fq_push, fq_full, fq_pop, fq_empty;
  logic                              fq_fs_in, fq_fs_out;
  logic [NUM_CHANNELS-1:0][CH_W-1:0] fq_frame_in, fq_frame_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT:   cfg_nxt.timeout_ticks = cfg_data;
        REG_VALID_MIN: cfg_nxt.valid_min     = cfg_data;
        REG_VALID_MAX: cfg_nxt.valid_max     = cfg_data;
        REG_FILL:      cfg_nxt.fill_value    = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.valid_min     <= VALID_MIN_RST;
      cfg_r.valid_max     <= VALID_MAX_RST;
      cfg_r.fill_value    <= FILL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcp_front #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_byte_req  (in_byte_req),
    .q_full       (fq_full),
    .q_push       (fq_push),
    .q_failsafe   (fq_fs_in),
    .q_frame      (fq_frame_in)
  );

  rcp_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata ({fq_fs_in, fq_frame_in}),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata ({fq_fs_out, fq_frame_out}),
    .empty (fq_empty)
  );

  rcp_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (fq_empty),
    .q_failsafe        (fq_fs_out),
    .q_frame           (fq_frame_out),
    .q_pop             (fq_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_failsafe      (out_failsafe),
    .out_last          (out_last)
  );

endmodule

@@ sv/rcp_checker.sv @@
// ----------------------------------------------------------------------------
// rcp_checker
// port-level checks on the channel result stream
// ----------------------------------------------------------------------------
`include "rc_csv_frame_parser_macros.svh"

module rcp_checker
  import rcp_pkg::*;
#(
  parameter int NUM_CHANNELS = 14
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_empty,
  input logic             out_pop,
  input logic [IDX_W-1:0] out_channel_index,
  input logic [CH_W-1:0]  out_channel_value,
  input logic             out_failsafe,
  input logic             out_last
);

  `RCP_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_channel_value) && $stable(out_channel_index))
  `RCP_ASSERT_NOW(a_last_pos, !out_empty, out_last == (out_channel_index == IDX_W'(NUM_CHANNELS - 1)))
  `RCP_ASSERT_NEXT(a_frame_run, !out_empty && out_pop && !out_last, !out_empty && out_channel_index == $past(out_channel_index) + 4'd1 && out_failsafe == $past(out_failsafe))
  `RCP_ASSERT_NEXT(a_frame_restart, !out_empty && out_pop && out_last, out_empty || out_channel_index == 4'd0)

endmodule

bind rc_csv_frame_parser rcp_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_rcp_checker (.*);
